// ----- rtl/tnc_pkg.sv -----
// Shared types and constants for the top-N-by-count selection core.
// No dependencies; tnc_front, tnc_back and the top level import this package.
package tnc_pkg;

  // Table geometry
  localparam int MAX_ENTRIES = 64;
  localparam int CNT_W       = 24;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int TOTAL_W     = $clog2(MAX_ENTRIES + 1);
  localparam int TOPN_W      = 7;

  // Stream widths, padded to whole bytes
  localparam int IN_DATA_W   = ((CNT_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((IDX_W + CNT_W + 7) / 8) * 8;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  // Reset value of the top_n register
  localparam logic [TOPN_W-1:0] TOPN_RESET = TOPN_W'(10);

  // One classified item as it waits in the queue
  typedef struct packed {
    logic             is_run;
    logic [CNT_W-1:0] count;
  } q_item_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_LAST,
    BK_EMIT
  } bk_state_t;

endpackage

// ----- rtl/tnc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tnc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/tnc_front.sv -----
// Front end: accepts stream items, classifies them and queues them for the back end.
// Depends on tnc_pkg.
module tnc_front
  import tnc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,  // [23:0] count
  input  logic                 s_axis_tuser,  // [0] func
  output logic                 q_valid,
  output q_item_t              q_item,
  input  logic                 q_pop
);

  q_item_t             q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QFILL_W-1:0]  fill;
  logic                push;
  q_item_t             item_in;

  // Classify the incoming item; counts already fit the table width, so no clamp
  always_comb begin
    item_in.is_run = s_axis_tuser;
    item_in.count  = s_axis_tdata[CNT_W-1:0];
  end

  assign s_axis_tready = (fill != QFILL_W'(QUEUE_DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid       = (fill != '0);
  assign q_item        = q_mem[rd_ptr];

  // Store the item at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= item_in;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        fill <= fill + 1'b1;
      end else if (!push && q_pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/tnc_back.sv -----
// Back end: stores loaded counts and runs the repeated max-scan selection.
// Depends on tnc_pkg and tnc_ram.
module tnc_back
  import tnc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [TOPN_W-1:0]     top_n,
  input  logic                  q_valid,
  input  q_item_t               q_item,
  output logic                  q_pop,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [5:0] entry_index, [29:6] entry_count
  output logic                  m_axis_tuser,  // [0] empty_table
  output logic                  m_axis_tlast   // is_last
);

  bk_state_t             state;
  bk_state_t             state_next;
  logic [TOTAL_W-1:0]    total;
  logic [TOTAL_W-1:0]    n;
  logic [TOTAL_W-1:0]    k;
  logic [IDX_W-1:0]      scan_addr;
  logic [MAX_ENTRIES-1:0] taken;
  logic [IDX_W-1:0]      best_idx;
  logic [CNT_W-1:0]      best_cnt;
  logic                  found;
  logic                  rd_valid;
  logic [IDX_W-1:0]      rd_idx;
  logic [CNT_W-1:0]      ram_rdata;

  logic                  out_free;
  logic                  ram_we;
  logic                  empty_emit;
  logic                  run_start;
  logic                  emit;
  logic                  emit_last;
  logic                  scan_end;
  logic [TOTAL_W-1:0]    n_eff;
  logic [TOTAL_W-1:0]    topn_ext;

  tnc_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_ENTRIES)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (total[IDX_W-1:0]),
    .wdata (q_item.count),
    .raddr (scan_addr),
    .rdata (ram_rdata)
  );

  // Clip top_n to the number of loaded entries
  assign topn_ext = TOTAL_W'(top_n);
  assign n_eff    = (topn_ext > total) ? total : topn_ext;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign scan_end = (TOTAL_W'(scan_addr) + TOTAL_W'(1)) == total;

  // Control outputs of the sequencer
  always_comb begin
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    empty_emit = 1'b0;
    run_start  = 1'b0;
    emit       = 1'b0;
    emit_last  = 1'b0;
    case (state)
      BK_IDLE: begin
        q_pop      = q_valid && (!q_item.is_run || total != '0 || out_free);
        ram_we     = q_pop && !q_item.is_run && (total < TOTAL_W'(MAX_ENTRIES));
        empty_emit = q_pop && q_item.is_run && (total == '0);
        run_start  = q_pop && q_item.is_run && (total != '0);
      end
      BK_EMIT: begin
        emit      = out_free;
        emit_last = out_free && ((k + 1'b1) == n);
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (run_start && n_eff != '0) begin
          state_next = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (scan_end) begin
          state_next = BK_LAST;
        end
      end
      BK_LAST: begin
        state_next = BK_EMIT;
      end
      BK_EMIT: begin
        if (emit_last) begin
          state_next = BK_IDLE;
        end else if (emit) begin
          state_next = BK_SCAN;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Sequencer and table control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      total    <= '0;
      n        <= '0;
      k        <= '0;
      taken    <= '0;
      found    <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= (state == BK_SCAN);
      // Count loads; clear the table once a run finishes
      if (ram_we) begin
        total <= total + 1'b1;
      end else if ((run_start && n_eff == '0) || emit_last) begin
        total <= '0;
      end
      if (run_start) begin
        n     <= n_eff;
        k     <= '0;
        taken <= '0;
        found <= 1'b0;
      end else if (emit) begin
        k               <= k + 1'b1;
        taken[best_idx] <= 1'b1;
        found           <= 1'b0;
      end else if (rd_valid && !taken[rd_idx] && (!found || ram_rdata > best_cnt)) begin
        found <= 1'b1;
      end
    end
  end

  // Scan address, read tracking and running maximum
  always_ff @(posedge clk) begin
    rd_idx <= scan_addr;
    if (run_start || emit) begin
      scan_addr <= '0;
    end else if (state == BK_SCAN && !scan_end) begin
      scan_addr <= scan_addr + 1'b1;
    end
    // Strict compare keeps the earliest entry among equal counts
    if (rd_valid && !taken[rd_idx] && (!found || ram_rdata > best_cnt)) begin
      best_idx <= rd_idx;
      best_cnt <= ram_rdata;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit || empty_emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= OUT_DATA_W'({best_cnt, best_idx});
      m_axis_tuser <= 1'b0;
      m_axis_tlast <= emit_last;
    end else if (empty_emit) begin
      m_axis_tdata <= '0;
      m_axis_tuser <= 1'b1;
      m_axis_tlast <= 1'b1;
    end
  end

  // Checks
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= TOTAL_W'(MAX_ENTRIES))
    else $error("entry total exceeds table size");

  a_emit_found: assert property (@(posedge clk) disable iff (rst)
    (state == BK_EMIT) |-> found)
    else $error("emitting without a selected entry");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == BK_SCAN) |-> (k < n && n != '0))
    else $error("scan running past requested result count");

  a_clear_after_run: assert property (@(posedge clk) disable iff (rst)
    emit_last |=> (total == '0 && state == BK_IDLE))
    else $error("table not cleared after run");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == BK_IDLE))
    else $error("queue popped while a run is in progress");

endmodule

// ----- rtl/top_n_by_count_select_core.sv -----
// Top level of the top-N-by-count selection core: front end, queue, back end, config.
// Depends on tnc_pkg, tnc_front, tnc_back and tnc_ram.
//
// A load item (tuser = 0) appends its 24-bit count to a 64-entry table in the
// back end; loads beyond 64 entries are dropped. A run item (tuser = 1)
// emits min(top_n, loaded) entries in descending count order, ties in load
// order, with tlast on the final one, and then empties the table. An empty
// table gives one item with tuser (empty_table) set. Each result is found
// by one full scan of the count RAM through its single read port, followed
// by the BK_LAST state, which settles the last read, and the BK_EMIT state,
// which emits the result; output stalls lengthen a run.
// A four-item queue lets new items be accepted while a run is in progress.
// Write top_n only while the core is idle.
module top_n_by_count_select_core
  import tnc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [TOPN_W-1:0]     cfg_wdata,      // top_n
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [23:0] count
  input  logic                  s_axis_tuser,   // [0] func
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [5:0] entry_index, [29:6] entry_count
  output logic                  m_axis_tuser,   // [0] empty_table
  output logic                  m_axis_tlast    // is_last
);

  logic [TOPN_W-1:0] top_n;
  logic              q_valid;
  q_item_t           q_item;
  logic              q_pop;

  // Hold the top_n register
  always_ff @(posedge clk) begin
    if (rst) begin
      top_n <= TOPN_RESET;
    end else if (cfg_we) begin
      top_n <= cfg_wdata;
    end
  end

  tnc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  tnc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .top_n         (top_n),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for top_n_by_count_select_core: streams load and run items,
// ranks the loaded counts in a local model and checks every emitted entry.
// Depends on tnc_pkg and the RTL under rtl/.
`timescale 1ns / 100ps

module tb_top;
  import tnc_pkg::*;

  localparam logic FUNC_LOAD     = 1'b0;
  localparam logic FUNC_RUN      = 1'b1;
  localparam int   SETTLE_CYCLES = 100;
  localparam int   TIMEOUT_NS    = 6_000_000;

  typedef struct {
    logic [IDX_W-1:0] index;
    logic [CNT_W-1:0] count;
    logic             empty;
    logic             last;
  } ranked_entry_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [TOPN_W-1:0]     cfg_wdata;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // [23:0] count
  logic                  s_axis_tuser;   // [0] func
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // [5:0] entry_index, [29:6] entry_count
  logic                  m_axis_tuser;   // [0] empty_table
  logic                  m_axis_tlast;   // is_last

  // Local copy of the table and the register
  logic [CNT_W-1:0]  loaded_counts [MAX_ENTRIES];
  int                loaded_total = 0;
  logic [TOPN_W-1:0] top_n_shadow = TOPN_RESET;
  ranked_entry_t     ranked_entries [$];

  int items_sent   = 0;
  int error_count  = 0;
  int src_idle_pct = 6;
  int snk_idle_pct = 66;
  int stall_left   = 0;

  top_n_by_count_select_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock and known input levels
  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_LOAD;
    m_axis_tready = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

  // Rank the loaded counts: highest first, earliest load wins a tie, then clear
  function automatic void rank_table();
    bit            taken [MAX_ENTRIES];
    int            n;
    int            best;
    ranked_entry_t entry;
    if (loaded_total == 0) begin
      entry = '{index: '0, count: '0, empty: 1'b1, last: 1'b1};
      ranked_entries.push_back(entry);
      return;
    end
    n = (int'(top_n_shadow) > loaded_total) ? loaded_total : int'(top_n_shadow);
    foreach (taken[j]) taken[j] = 1'b0;
    for (int k = 0; k < n; k++) begin
      best = -1;
      for (int j = 0; j < loaded_total; j++) begin
        if (!taken[j] && (best < 0 || loaded_counts[j] > loaded_counts[best])) best = j;
      end
      taken[best]  = 1'b1;
      entry.index  = IDX_W'(best);
      entry.count  = loaded_counts[best];
      entry.empty  = 1'b0;
      entry.last   = (k == n - 1);
      ranked_entries.push_back(entry);
    end
    loaded_total = 0;
  endfunction

  // Offer one item after a random gap, hold until accepted, then predict
  task automatic send_item(input logic func, input logic [CNT_W-1:0] count);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'(count);
    s_axis_tuser  <= func;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    if (func == FUNC_LOAD) begin
      if (loaded_total < MAX_ENTRIES) begin
        loaded_counts[loaded_total] = count;
        loaded_total++;
      end
    end else begin
      rank_table();
    end
  endtask

  // Drop valid, wait for all expected entries, then let queued loads finish
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (ranked_entries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write top_n once the core is idle
  task automatic write_top_n(input logic [TOPN_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    top_n_shadow = value;
  endtask

  // Mix small tie-prone counts, extremes and full-range values
  function automatic logic [CNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 25) return CNT_W'($urandom_range(3));
    if (r < 32) return '1;
    if (r < 36) return '0;
    return CNT_W'($urandom);
  endfunction

  function automatic logic [TOPN_W-1:0] pick_top_n();
    case ($urandom_range(5))
      0:       return TOPN_W'(0);
      1:       return TOPN_W'(1);
      2:       return TOPN_W'(64);
      3:       return TOPN_W'(2);
      default: return TOPN_W'($urandom_range(64));
    endcase
  endfunction

  // Receiver: random stalls, or a long hold-off when requested
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Compare each accepted entry with the oldest prediction
  always @(posedge clk) begin : check_entries
    ranked_entry_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (ranked_entries.size() == 0) begin
        $error("unexpected entry: index %0d count %0d", m_axis_tdata[IDX_W-1:0],
               m_axis_tdata[IDX_W +: CNT_W]);
        error_count++;
      end else begin
        want = ranked_entries.pop_front();
        check_field("entry_index", want.index, m_axis_tdata[IDX_W-1:0]);
        check_field("entry_count", want.count, m_axis_tdata[IDX_W +: CNT_W]);
        check_field("empty_table", want.empty, m_axis_tuser);
        check_field("is_last", want.last, m_axis_tlast);
      end
    end
  end

  // Run on an empty table after reset
  task automatic test_empty_run();
    send_item(FUNC_RUN, '0);
  endtask

  // Extreme counts, duplicated maximum; reset top_n of 10 clipped to seven
  task automatic test_count_extremes();
    send_item(FUNC_LOAD, 24'h000000);
    send_item(FUNC_LOAD, 24'hFFFFFF);
    send_item(FUNC_LOAD, 24'h000001);
    send_item(FUNC_LOAD, 24'hFFFFFF);
    send_item(FUNC_LOAD, 24'h800000);
    send_item(FUNC_LOAD, 24'h555555);
    send_item(FUNC_LOAD, 24'hAAAAAA);
    send_item(FUNC_RUN, 24'hFFFFFF);
  endtask

  // Stop partway through a three-way tie
  task automatic test_tie_cutoff();
    write_top_n(TOPN_W'(2));
    send_item(FUNC_LOAD, 24'd5);
    send_item(FUNC_LOAD, 24'd7);
    send_item(FUNC_LOAD, 24'd7);
    send_item(FUNC_LOAD, 24'd7);
    send_item(FUNC_RUN, '0);
  endtask

  // Zero top_n gives nothing but still clears, so the next run sees an empty table
  task automatic test_zero_top_n();
    write_top_n(TOPN_W'(0));
    send_item(FUNC_LOAD, 24'd3);
    send_item(FUNC_RUN, '0);
    send_item(FUNC_RUN, '0);
  endtask

  // Overfill the table; loads past the last entry are dropped
  task automatic test_table_full();
    write_top_n(TOPN_W'(64));
    repeat (MAX_ENTRIES + 4) send_item(FUNC_LOAD, pick_count());
    send_item(FUNC_RUN, pick_count());
  endtask

  // Hold the receiver off while items keep coming, so the input stalls
  task automatic test_backpressure();
    write_top_n(TOPN_W'(64));
    @(posedge clk);
    stall_left = 500;
    repeat (20) send_item(FUNC_LOAD, pick_count());
    send_item(FUNC_RUN, '0);
    repeat (8) send_item(FUNC_LOAD, pick_count());
    send_item(FUNC_RUN, '0);
    send_item(FUNC_RUN, '0);
  endtask

  // Load batches of random size followed by a run, with empty and repeated runs
  task automatic test_random_phase(input int src_pct, input int snk_pct, input int budget);
    int start;
    int batch;
    int roll;
    int loads;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    start = items_sent;
    batch = 0;
    while (items_sent - start < budget) begin
      if (batch % 3 == 0) write_top_n(pick_top_n());
      roll = $urandom_range(99);
      if (roll < 8) loads = 0;
      else if (roll < 18) loads = $urandom_range(60, 70);
      else loads = $urandom_range(1, 12);
      repeat (loads) send_item(FUNC_LOAD, pick_count());
      send_item(FUNC_RUN, pick_count());
      if ($urandom_range(99) < 5) send_item(FUNC_RUN, pick_count());
      batch++;
    end
  endtask

  // Test sequence
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_run();
    test_count_extremes();
    test_tie_cutoff();
    test_zero_top_n();
    test_table_full();
    test_random_phase(6, 66, 95);
    test_random_phase(66, 6, 95);
    test_random_phase(0, 0, 95);
    test_backpressure();

    settle();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
